// File: hdl/pdvd_pkg.sv
package pdvd_pkg;

  localparam int unsigned PhaseW = 10;

  typedef enum logic [PhaseW-1:0] {
    PH_MIN_X   = 10'b00_0000_0001,
    PH_MIN_Y   = 10'b00_0000_0010,
    PH_NPOLY   = 10'b00_0000_0100,
    PH_NPTS    = 10'b00_0000_1000,
    PH_FIRST_X = 10'b00_0001_0000,
    PH_FIRST_Y = 10'b00_0010_0000,
    PH_DELTA_X = 10'b00_0100_0000,
    PH_DELTA_Y = 10'b00_1000_0000,
    PH_DONE    = 10'b01_0000_0000,
    PH_DRAIN   = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_POINT      = 2'd0,
    KIND_EMPTY_POLY = 2'd1,
    KIND_EMPTY_SET  = 2'd2,
    KIND_ERROR      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TRUNCATED = 2'd1,
    ERR_TRAILING  = 2'd2,
    ERR_OVERLONG  = 2'd3
  } err_e;

  // Varint byte limits: last byte index for counts and for 64-bit values
  localparam logic [3:0] CountLastPos = 4'd4;
  localparam logic [3:0] WideLastPos  = 4'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_payload;
  } item_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic [31:0]        polygon_number;
    logic [31:0]        point_number;
    logic               last_in_polygon;
    logic               last_in_set;
    err_e               error_code;
  } res_t;

endpackage

// File: hdl/pdvd_in_if.sv
interface pdvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_payload;

  modport source (output valid, output data_byte, output end_of_payload, input ready);
  modport sink (input valid, input data_byte, input end_of_payload, output ready);
endinterface

// File: hdl/pdvd_out_if.sv
interface pdvd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [63:0] x;
  logic signed [63:0] y;
  logic [31:0]        polygon_number;
  logic [31:0]        point_number;
  logic               last_in_polygon;
  logic               last_in_set;
  logic [1:0]         error_code;

  modport source (
    output valid, output kind, output x, output y, output polygon_number,
    output point_number, output last_in_polygon, output last_in_set,
    output error_code, input ready
  );
  modport sink (
    input valid, input kind, input x, input y, input polygon_number,
    input point_number, input last_in_polygon, input last_in_set,
    input error_code, output ready
  );
endinterface

// File: hdl/pdvd_in_stage.sv
module pdvd_in_stage
  import pdvd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  item_t        in_item_i,
  output logic         in_ready_o,
  input  logic         advance_i,
  output logic         item_valid_o,
  output item_t        item_o
);

  logic  valid_q;
  item_t item_q;

  assign in_ready_o   = !valid_q || advance_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

// File: hdl/pdvd_core.sv
module pdvd_core
  import pdvd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  advance_i,
  input  item_t item_i,
  output logic  res_valid_o,
  output res_t  res_o
);

  phase_e      phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  pos_q, pos_d;
  logic [63:0] min_x_q, min_x_d, min_y_q, min_y_d;
  logic [31:0] poly_left_q, poly_left_d, pts_left_q, pts_left_d;
  logic [31:0] poly_seen_q, poly_seen_d, pt_seen_q, pt_seen_d;
  logic [63:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [63:0] pend_x_q, pend_x_d;

  logic [7:0]  b;
  logic        eop;
  logic        is_count;
  logic [3:0]  last_pos;
  logic        bad_bits;
  logic [5:0]  shamt;
  logic [63:0] acc_new;
  logic [63:0] unzig_v;
  logic [63:0] add_base;
  logic [63:0] add_val;
  logic [63:0] sum;
  logic        err;
  logic        clear;

  assign b        = item_i.data_byte;
  assign eop      = item_i.end_of_payload;
  assign is_count = (phase_q == PH_NPOLY) || (phase_q == PH_NPTS);
  assign last_pos = is_count ? CountLastPos : WideLastPos;
  assign bad_bits = is_count ? (|b[7:4]) : (|b[7:1]);
  assign shamt    = 6'({2'b00, pos_q} * 6'd7);
  assign acc_new  = acc_q | (64'({57'd0, b[6:0]}) << shamt);
  assign unzig_v  = (acc_new >> 1) ^ {64{acc_new[0]}};

  // One shared 64-bit adder for all coordinate sums
  always_comb begin
    case (phase_q)
      PH_FIRST_X: begin add_base = min_x_q;  add_val = acc_new; end
      PH_FIRST_Y: begin add_base = min_y_q;  add_val = acc_new; end
      PH_DELTA_X: begin add_base = prev_x_q; add_val = unzig_v; end
      default:    begin add_base = prev_y_q; add_val = unzig_v; end
    endcase
  end
  assign sum = add_base + add_val;

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    min_x_d     = min_x_q;
    min_y_d     = min_y_q;
    poly_left_d = poly_left_q;
    pts_left_d  = pts_left_q;
    poly_seen_d = poly_seen_q;
    pt_seen_d   = pt_seen_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    pend_x_d    = pend_x_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_POINT, error_code: ERR_NONE, default: '0};
    err         = 1'b0;
    clear       = 1'b0;

    if (phase_q == PH_DRAIN) begin
      clear = eop;
    end else if (phase_q == PH_DONE) begin
      res_valid_o      = 1'b1;
      res_o.kind       = KIND_ERROR;
      res_o.error_code = ERR_TRAILING;
      phase_d          = PH_DRAIN;
      clear            = eop;
    end else begin
      if (pos_q == last_pos && bad_bits) begin
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_ERROR;
        res_o.error_code = ERR_OVERLONG;
        err              = 1'b1;
      end else if (b[7]) begin
        acc_d = acc_new;
        pos_d = pos_q + 4'd1;
      end else begin
        acc_d = '0;
        pos_d = '0;
        unique case (phase_q)
          PH_MIN_X: begin
            min_x_d = unzig_v;
            phase_d = PH_MIN_Y;
          end
          PH_MIN_Y: begin
            min_y_d = unzig_v;
            phase_d = PH_NPOLY;
          end
          PH_NPOLY: begin
            poly_left_d = acc_new[31:0];
            poly_seen_d = '0;
            if (acc_new[31:0] == 32'd0) begin
              phase_d           = PH_DONE;
              res_valid_o       = 1'b1;
              res_o.kind        = KIND_EMPTY_SET;
              res_o.last_in_set = 1'b1;
            end else begin
              phase_d = PH_NPTS;
            end
          end
          PH_NPTS: begin
            pts_left_d = acc_new[31:0];
            pt_seen_d  = '0;
            if (acc_new[31:0] == 32'd0) begin
              poly_seen_d           = poly_seen_q + 32'd1;
              poly_left_d           = poly_left_q - 32'd1;
              phase_d               = (poly_left_q == 32'd1) ? PH_DONE : PH_NPTS;
              res_valid_o           = 1'b1;
              res_o.kind            = KIND_EMPTY_POLY;
              res_o.polygon_number  = poly_seen_q;
              res_o.last_in_polygon = 1'b1;
              res_o.last_in_set     = (poly_left_q == 32'd1);
            end else begin
              phase_d = PH_FIRST_X;
            end
          end
          PH_FIRST_X, PH_DELTA_X: begin
            pend_x_d = sum;
            phase_d  = (phase_q == PH_FIRST_X) ? PH_FIRST_Y : PH_DELTA_Y;
          end
          PH_FIRST_Y, PH_DELTA_Y: begin
            prev_x_d             = pend_x_q;
            prev_y_d             = sum;
            pt_seen_d            = pt_seen_q + 32'd1;
            pts_left_d           = pts_left_q - 32'd1;
            res_valid_o          = 1'b1;
            res_o.kind           = KIND_POINT;
            res_o.x              = pend_x_q;
            res_o.y              = sum;
            res_o.polygon_number = poly_seen_q;
            res_o.point_number   = pt_seen_q;
            if (pts_left_q == 32'd1) begin
              // Last point closes the polygon
              poly_seen_d           = poly_seen_q + 32'd1;
              poly_left_d           = poly_left_q - 32'd1;
              phase_d               = (poly_left_q == 32'd1) ? PH_DONE : PH_NPTS;
              res_o.last_in_polygon = 1'b1;
              res_o.last_in_set     = (poly_left_q == 32'd1);
            end else begin
              phase_d = PH_DELTA_X;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end

      if (err) begin
        phase_d = PH_DRAIN;
        clear   = eop;
      end else if (eop) begin
        // Payload ended before the set closed: report truncation instead
        if (phase_d != PH_DONE) begin
          res_valid_o      = 1'b1;
          res_o            = '{kind: KIND_ERROR, error_code: ERR_TRUNCATED, default: '0};
        end
        clear = 1'b1;
      end
    end

    if (clear) begin
      phase_d     = PH_MIN_X;
      acc_d       = '0;
      pos_d       = '0;
      min_x_d     = '0;
      min_y_d     = '0;
      poly_left_d = '0;
      pts_left_d  = '0;
      poly_seen_d = '0;
      pt_seen_d   = '0;
      prev_x_d    = '0;
      prev_y_d    = '0;
      pend_x_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MIN_X;
      acc_q       <= '0;
      pos_q       <= '0;
      min_x_q     <= '0;
      min_y_q     <= '0;
      poly_left_q <= '0;
      pts_left_q  <= '0;
      poly_seen_q <= '0;
      pt_seen_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      pend_x_q    <= '0;
    end else if (advance_i) begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      min_x_q     <= min_x_d;
      min_y_q     <= min_y_d;
      poly_left_q <= poly_left_d;
      pts_left_q  <= pts_left_d;
      poly_seen_q <= poly_seen_d;
      pt_seen_q   <= pt_seen_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      pend_x_q    <= pend_x_d;
    end
  end

endmodule

// File: hdl/pdvd_out_stage.sv
module pdvd_out_stage
  import pdvd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic res_valid_i,
  input  res_t res_i,
  output logic free_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_valid_i;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// File: hdl/polygon_delta_varint_decoder_top.sv
// Polygon delta-varint decoder: takes one payload byte per item and returns at
// most one result per byte (a point, an empty polygon, an empty set or an
// error). A byte is taken every cycle while the result side keeps up; a byte
// passes through an input register, a combinational decode against the running
// state (varint shift-or and one shared 64-bit adder), and a result register,
// which loads the decode result only when it is empty or being read out.
// The rate of one byte per cycle, while the result side keeps up, is set by
// the decode state register, which each byte updates.
module polygon_delta_varint_decoder_top
  import pdvd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  pdvd_in_if.sink    in_i,
  pdvd_out_if.source out_o
);

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  advance;
  logic  free;
  logic  res_valid;
  res_t  res;
  res_t  res_out;

  assign in_item.data_byte      = in_i.data_byte;
  assign in_item.end_of_payload = in_i.end_of_payload;
  assign advance                = item_valid && free;

  pdvd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_item_i    (in_item),
    .in_ready_o   (in_i.ready),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  pdvd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pdvd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (free),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .res_o       (res_out)
  );

  assign out_o.kind            = res_out.kind;
  assign out_o.x               = res_out.x;
  assign out_o.y               = res_out.y;
  assign out_o.polygon_number  = res_out.polygon_number;
  assign out_o.point_number    = res_out.point_number;
  assign out_o.last_in_polygon = res_out.last_in_polygon;
  assign out_o.last_in_set     = res_out.last_in_set;
  assign out_o.error_code      = res_out.error_code;

endmodule

// File: tb/polygon_decode_checker.sv
`timescale 1ns / 1ps

module polygon_decode_checker
  import pdvd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  pdvd_in_if   byte_mon_i,
  pdvd_out_if  res_mon_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);

  // Decoder state as the byte stream drives it
  phase_e      dec_phase;
  logic [63:0] acc;
  logic [3:0]  acc_pos;
  logic [63:0] base_x, base_y;
  logic [31:0] polys_to_go, pts_to_go;
  logic [31:0] poly_idx, pt_idx;
  logic [63:0] last_x, last_y, held_x;

  res_t expected_q[$];
  res_t want;
  int   fail_count = 0;
  int   checked = 0;

  function automatic void restart();
    dec_phase   = PH_MIN_X;
    acc         = '0;
    acc_pos     = '0;
    base_x      = '0;
    base_y      = '0;
    polys_to_go = '0;
    pts_to_go   = '0;
    poly_idx    = '0;
    pt_idx      = '0;
    last_x      = '0;
    last_y      = '0;
    held_x      = '0;
  endfunction

  function automatic logic [63:0] unzigzag(input logic [63:0] v);
    return (v >> 1) ^ {64{v[0]}};
  endfunction

  // Close the current polygon; high when the whole set is complete
  function automatic bit finish_polygon();
    poly_idx++;
    polys_to_go--;
    if (polys_to_go == 0) begin
      dec_phase = PH_DONE;
      return 1'b1;
    end
    dec_phase = PH_NPTS;
    return 1'b0;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic eop, output res_t r);
    bit          made;
    bit          bad;
    bit          is_count;
    logic [3:0]  end_pos;
    logic [7:0]  bad_bits;
    logic [63:0] v;
    logic [63:0] y_new;
    r    = '0;
    made = 1'b0;
    bad  = 1'b0;
    if (dec_phase == PH_DRAIN) begin
      if (eop) restart();
      return 1'b0;
    end
    if (dec_phase == PH_DONE) begin
      r.kind       = KIND_ERROR;
      r.error_code = ERR_TRAILING;
      if (eop) restart();
      else dec_phase = PH_DRAIN;
      return 1'b1;
    end
    is_count = (dec_phase == PH_NPOLY) || (dec_phase == PH_NPTS);
    end_pos  = is_count ? CountLastPos : WideLastPos;
    bad_bits = is_count ? 8'hF0 : 8'hFE;
    if (acc_pos > end_pos) acc_pos = end_pos;
    if (acc_pos == 0) acc = '0;
    if (acc_pos == end_pos && (b & bad_bits) != 0) begin
      r.kind       = KIND_ERROR;
      r.error_code = ERR_OVERLONG;
      made         = 1'b1;
      bad          = 1'b1;
    end else begin
      acc |= 64'(b[6:0]) << (7 * acc_pos);
      if (b[7]) begin
        acc_pos++;
      end else begin
        v       = acc;
        acc_pos = '0;
        acc     = '0;
        case (dec_phase)
          PH_MIN_X: begin
            base_x    = unzigzag(v);
            dec_phase = PH_MIN_Y;
          end
          PH_MIN_Y: begin
            base_y    = unzigzag(v);
            dec_phase = PH_NPOLY;
          end
          PH_NPOLY: begin
            polys_to_go = v[31:0];
            poly_idx    = '0;
            if (polys_to_go == 0) begin
              dec_phase     = PH_DONE;
              r.kind        = KIND_EMPTY_SET;
              r.last_in_set = 1'b1;
              made          = 1'b1;
            end else begin
              dec_phase = PH_NPTS;
            end
          end
          PH_NPTS: begin
            pts_to_go = v[31:0];
            pt_idx    = '0;
            if (pts_to_go == 0) begin
              r.kind            = KIND_EMPTY_POLY;
              r.polygon_number  = poly_idx;
              r.last_in_polygon = 1'b1;
              r.last_in_set     = finish_polygon();
              made              = 1'b1;
            end else begin
              dec_phase = PH_FIRST_X;
            end
          end
          PH_FIRST_X: begin
            held_x    = base_x + v;
            dec_phase = PH_FIRST_Y;
          end
          PH_DELTA_X: begin
            held_x    = last_x + unzigzag(v);
            dec_phase = PH_DELTA_Y;
          end
          default: begin
            // y of a point: offset from the minimum or delta from the last point
            y_new            = (dec_phase == PH_FIRST_Y) ? base_y + v : last_y + unzigzag(v);
            r.kind           = KIND_POINT;
            r.x              = held_x;
            r.y              = y_new;
            r.polygon_number = poly_idx;
            r.point_number   = pt_idx;
            last_x           = held_x;
            last_y           = y_new;
            pt_idx++;
            pts_to_go--;
            if (pts_to_go == 0) begin
              r.last_in_polygon = 1'b1;
              r.last_in_set     = finish_polygon();
            end else begin
              dec_phase = PH_DELTA_X;
            end
            made = 1'b1;
          end
        endcase
      end
    end
    if (bad) begin
      if (eop) restart();
      else dec_phase = PH_DRAIN;
      return made;
    end
    if (eop) begin
      // end of payload before the set is complete replaces any other result
      if (dec_phase != PH_DONE) begin
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = ERR_TRUNCATED;
        made         = 1'b1;
      end
      restart();
    end
    return made;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart();
      expected_q.delete();
    end else begin
      if (byte_mon_i.valid && byte_mon_i.ready) begin
        if (decode_byte(byte_mon_i.data_byte, byte_mon_i.end_of_payload, want)) begin
          expected_q.push_back(want);
        end
      end
      if (res_mon_i.valid && res_mon_i.ready) begin
        checked++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d error %0d",
                   $time, res_mon_i.kind, res_mon_i.error_code);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind", 64'(want.kind), 64'(res_mon_i.kind));
          check_field("x", want.x, res_mon_i.x);
          check_field("y", want.y, res_mon_i.y);
          check_field("polygon_number", 64'(want.polygon_number),
                      64'(res_mon_i.polygon_number));
          check_field("point_number", 64'(want.point_number), 64'(res_mon_i.point_number));
          check_field("last_in_polygon", 64'(want.last_in_polygon),
                      64'(res_mon_i.last_in_polygon));
          check_field("last_in_set", 64'(want.last_in_set), 64'(res_mon_i.last_in_set));
          check_field("error_code", 64'(want.error_code), 64'(res_mon_i.error_code));
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_q.size();
    checked_o    <= checked;
  end

endmodule

// File: tb/tb_polygon_delta_varint_decoder_top.sv
`timescale 1ns / 1ps

module tb_polygon_delta_varint_decoder_top;
  import pdvd_pkg::*;

  localparam int ItemTarget  = 1650;
  localparam int QuietLimit  = 1000;
  localparam int DrainCycles = 8;

  typedef enum int {
    FLAW_NONE,
    FLAW_TRUNCATE,
    FLAW_TRAILING,
    FLAW_OVERLONG,
    FLAW_NOISE
  } flaw_e;

  logic clk_i;
  logic rst_ni;

  pdvd_in_if  byte_if ();
  pdvd_out_if res_if ();

  int fail_count;
  int pending;
  int checked;

  polygon_delta_varint_decoder_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (res_if)
  );

  polygon_decode_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_mon_i   (byte_if),
    .res_mon_i    (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  item_t      stim_q[$];
  logic [7:0] pay_bytes[$];
  flaw_e      flaw;
  bit         broken;
  int         field_no;
  int         bad_field;
  int         counted;
  int         flaw_tally[5];

  // Move the payload into the stimulus, marking its last byte
  task automatic flush_payload();
    item_t it;
    foreach (pay_bytes[k]) begin
      it.data_byte      = pay_bytes[k];
      it.end_of_payload = (k == pay_bytes.size() - 1);
      stim_q.push_back(it);
    end
    pay_bytes.delete();
  endtask

  function automatic logic [63:0] pick_wide();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 127));
      1: return 64'($urandom_range(0, 16383));
      2: return r;
      3: begin
        case ($urandom_range(0, 4))
          0: return 64'h0;
          1: return 64'hFFFF_FFFF_FFFF_FFFF;
          2: return 64'h7FFF_FFFF_FFFF_FFFF;
          3: return 64'h8000_0000_0000_0000;
          default: return 64'h1;
        endcase
      end
      4: return 64'h1 << $urandom_range(0, 63);
      default: return r >> $urandom_range(0, 63);
    endcase
  endfunction

  // Append one varint, now and then padded with empty groups; corrupt the
  // chosen field when an overlong varint is wanted
  task automatic put_varint(input logic [63:0] v, input bit is_count);
    int          limit;
    int          nat_len;
    int          len;
    logic [63:0] rest;
    if (broken) return;
    limit = is_count ? 5 : 10;
    if (flaw == FLAW_OVERLONG && field_no == bad_field) begin
      repeat (limit - 1) pay_bytes.push_back(8'($urandom) | 8'h80);
      if (is_count) pay_bytes.push_back(8'($urandom) | (8'h10 << $urandom_range(0, 3)));
      else pay_bytes.push_back(8'($urandom) | (8'h02 << $urandom_range(0, 6)));
      broken = 1'b1;
      return;
    end
    field_no++;
    nat_len = 1;
    rest    = v >> 7;
    while (rest != 0) begin
      nat_len++;
      rest = rest >> 7;
    end
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(nat_len, limit) : nat_len;
    for (int k = 0; k < len; k++) begin
      pay_bytes.push_back({(k != len - 1), 7'(v >> (7 * k))});
    end
  endtask

  task automatic build_payload(input flaw_e f);
    int polys;
    int pts;
    int keep;
    int useful;
    bit huge;
    flaw      = f;
    broken    = 1'b0;
    field_no  = 0;
    bad_field = $urandom_range(0, 8);
    pay_bytes.delete();
    if (f == FLAW_NOISE) begin
      repeat ($urandom_range(1, 6)) pay_bytes.push_back(8'($urandom));
      useful = pay_bytes.size();
    end else begin
      put_varint(pick_wide(), 1'b0);
      put_varint(pick_wide(), 1'b0);
      // a huge count only makes sense in a payload that is cut short anyway
      huge  = (f == FLAW_TRUNCATE) && ($urandom_range(0, 3) == 0);
      polys = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      if (huge) polys = $urandom_range(1, 3);
      put_varint(huge ? 64'($urandom) : 64'(polys), 1'b1);
      repeat (polys) begin
        pts = ($urandom_range(0, 7) == 0) ? 0 :
              ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        put_varint(64'(pts), 1'b1);
        repeat (pts) begin
          put_varint(pick_wide(), 1'b0);
          put_varint(pick_wide(), 1'b0);
        end
      end
      useful = pay_bytes.size();
      if (broken) repeat ($urandom_range(0, 2)) pay_bytes.push_back(8'($urandom));
      if (f == FLAW_TRUNCATE && pay_bytes.size() > 1) begin
        keep = $urandom_range(1, pay_bytes.size() - 1);
        while (pay_bytes.size() > keep) void'(pay_bytes.pop_back());
        useful = keep;
      end
      if (f == FLAW_TRAILING) begin
        useful++;
        repeat ($urandom_range(1, 3)) pay_bytes.push_back(8'($urandom));
      end
    end
    counted += useful;
    flaw_tally[f]++;
    flush_payload();
  endtask

  initial begin : stimulus
    int    gap;
    int    roll;
    bit    calm;
    flaw_e f;
    byte_if.valid          <= 1'b0;
    byte_if.data_byte      <= 8'h00;
    byte_if.end_of_payload <= 1'b0;
    rst_ni                 <= 1'b0;

    // empty set, then a trailing byte that ends the payload
    pay_bytes = '{8'h00, 8'h00, 8'h00, 8'hFF};
    flush_payload();
    // payload ends while the polygon count is still expected
    pay_bytes = '{8'h01, 8'h00};
    flush_payload();
    // polygon count with a fifth byte too wide, then drop up to the end
    pay_bytes = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h10, 8'h00, 8'h00};
    flush_payload();
    // an empty polygon, then one with a first point and a delta point
    pay_bytes = '{8'h00, 8'h00, 8'h02, 8'h00, 8'h02, 8'h7F, 8'h01, 8'h03, 8'h02};
    flush_payload();
    counted = stim_q.size();

    while (counted < ItemTarget) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) f = FLAW_NONE;
      else if (roll < 80) f = FLAW_TRUNCATE;
      else if (roll < 88) f = FLAW_TRAILING;
      else if (roll < 96) f = FLAW_OVERLONG;
      else f = FLAW_NOISE;
      build_payload(f);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_q[i]) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      byte_if.valid          <= 1'b1;
      byte_if.data_byte      <= stim_q[i].data_byte;
      byte_if.end_of_payload <= stim_q[i].end_of_payload;
      do @(posedge clk_i); while (!byte_if.ready);
    end
    byte_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Fed %0d bytes: 4 directed payloads, %0d clean, %0d cut short, %0d with trailing",
             stim_q.size(), flaw_tally[FLAW_NONE], flaw_tally[FLAW_TRUNCATE],
             flaw_tally[FLAW_TRAILING]);
    $display("bytes, %0d with an overlong varint, %0d of noise; %0d results compared.",
             flaw_tally[FLAW_OVERLONG], flaw_tally[FLAW_NOISE], checked);
    if (pending != 0) begin
      $display("%0t: results missing, expected %0d more, got 0", $time, pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    int n;
    bit calm;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    n = 0;
    forever begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      n++;
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // End the run when neither channel moves an item for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, QuietLimit);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
